@@ rtl/i2cms_pkg.sv @@
package i2cms_pkg;

   // Bits per data byte on the bus
   localparam int BYTE_BITS = 8;

   // Result step counter: wide enough for the longest command (send byte)
   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] SEND_LAST_STEP = STEP_W'(3 * BYTE_BITS);
   localparam logic [STEP_W-1:0] READ_LAST_STEP = STEP_W'(2 * BYTE_BITS + 1);

   // Hold length register
   localparam int HOLD_W = 16;
   localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(100);

   // Bus commands
   typedef enum logic [2:0] {
      OP_START = 3'd0,
      OP_STOP  = 3'd1,
      OP_ACK   = 3'd2,
      OP_NACK  = 3'd3,
      OP_WAIT  = 3'd4,
      OP_SEND  = 3'd5,
      OP_READ  = 3'd6
   } op_type;

   // Command item
   typedef struct packed {
      logic [2:0]           opcode;
      logic [BYTE_BITS-1:0] tx_byte;
      logic [BYTE_BITS-1:0] sda_samples;
   } req_payload_type;

   // Pin change item
   typedef struct packed {
      logic                 scl_level;
      logic                 sda_level;
      logic                 hold_after;
      logic [BYTE_BITS-1:0] rx_byte;
      logic                 ok;
      logic                 last;
   } rsp_payload_type;

endpackage

@@ rtl/i2cms_req_if.sv @@
interface i2cms_req_if;
   logic                       valid;
   logic                       ready;
   i2cms_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/i2cms_rsp_if.sv @@
interface i2cms_rsp_if;
   logic                       valid;
   logic                       ready;
   i2cms_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/i2cms_csr_if.sv @@
interface i2cms_csr_if;
   logic                          valid;
   logic                          ready;
   logic [i2cms_pkg::HOLD_W-1:0] payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/i2c_master_bit_sequencer_core.sv @@
// Channel   | Dir | Payload                                     | Transfer
// ----------+-----+---------------------------------------------+------------------
// req_if    | in  | opcode, tx_byte, sda_samples                | valid & ready
// rsp_if    | out | scl_level, sda_level, hold_after, rx_byte,  | valid & ready
//           |     | ok, last                                    |
// csr_if    | in  | hold_cycles (16 bits)                       | valid & ready
//
// A command is taken while idle, then yields one pin change per cycle (start 2-4,
// stop/ack/no-ack/wait-ack 4, send byte 25, read byte 18) when the output is not
// stalled; after each change flagged hold_after, the hold down-counter, loaded with
// max(hold_cycles,1), must reach zero first. Opcode seven is taken and yields nothing.
// Reset (synchronous) releases both pins, loads hold_cycles with 100 and
// empties the output register. A stalled result holds the sequencer in place.
module i2c_master_bit_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   i2cms_req_if.sink   req_if,
   i2cms_rsp_if.source rsp_if,
   i2cms_csr_if.sink   csr_if
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type                          state_ff, state_in;
   i2cms_pkg::op_type                  op_ff, op_in;
   logic [i2cms_pkg::STEP_W-1:0]       step_ff, step_in;
   logic [1:0]                         phase_ff, phase_in;
   logic [i2cms_pkg::BYTE_BITS-1:0]    txsh_ff, txsh_in;
   logic [i2cms_pkg::BYTE_BITS-1:0]    smp_ff, smp_in;
   logic [i2cms_pkg::BYTE_BITS-1:0]    rx_ff, rx_in;
   logic                               scl_ff, scl_in;
   logic                               sda_ff, sda_in;
   logic [i2cms_pkg::HOLD_W-1:0]       hold_cycles_ff, hold_cycles_in;
   logic [i2cms_pkg::HOLD_W-1:0]       hold_cnt_ff, hold_cnt_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   i2cms_pkg::rsp_payload_type         rsp_ff, rsp_in;

   i2cms_pkg::rsp_payload_type         res;
   logic                               req_xfer;
   logic                               issue;
   logic                               tx_shift;
   logic                               rx_shift;

   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.payload = rsp_ff;

   assign req_xfer = req_if.valid && req_if.ready;
   assign issue    = (state_ff == ST_RUN) && (hold_cnt_ff == '0)
                     && (!rsp_valid_ff || rsp_if.ready);

   // Pin change for the current step
   always_comb begin
      res          = '0;
      res.scl_level = scl_ff;
      res.sda_level = sda_ff;
      tx_shift     = 1'b0;
      rx_shift     = 1'b0;
      unique case (op_ff)
         i2cms_pkg::OP_START: begin
            unique case (step_ff[1:0])
               2'd0: begin
                  res.sda_level = 1'b1;
               end
               2'd1: begin
                  res.scl_level  = 1'b1;
                  res.sda_level  = 1'b1;
                  res.hold_after = 1'b1;
                  res.last       = !smp_ff[0];
               end
               2'd2: begin
                  res.scl_level  = 1'b1;
                  res.sda_level  = 1'b0;
                  res.hold_after = 1'b1;
                  res.last       = smp_ff[1];
               end
               default: begin
                  res.scl_level  = 1'b0;
                  res.sda_level  = 1'b0;
                  res.hold_after = 1'b1;
                  res.last       = 1'b1;
                  res.ok         = 1'b1;
               end
            endcase
         end
         i2cms_pkg::OP_STOP: begin
            res.hold_after = 1'b1;
            unique case (step_ff[1:0])
               2'd0: res.scl_level = 1'b0;
               2'd1: begin
                  res.scl_level = 1'b0;
                  res.sda_level = 1'b0;
               end
               2'd2: begin
                  res.scl_level = 1'b1;
                  res.sda_level = 1'b0;
               end
               default: begin
                  res.scl_level = 1'b1;
                  res.sda_level = 1'b1;
                  res.last      = 1'b1;
               end
            endcase
         end
         i2cms_pkg::OP_ACK, i2cms_pkg::OP_NACK: begin
            res.hold_after = 1'b1;
            unique case (step_ff[1:0])
               2'd0: res.scl_level = 1'b0;
               2'd1: begin
                  res.scl_level = 1'b0;
                  res.sda_level = (op_ff == i2cms_pkg::OP_NACK);
               end
               2'd2: res.scl_level = 1'b1;
               default: begin
                  res.scl_level = 1'b0;
                  res.last      = 1'b1;
               end
            endcase
         end
         i2cms_pkg::OP_WAIT: begin
            unique case (step_ff[1:0])
               2'd0: begin
                  res.scl_level  = 1'b0;
                  res.hold_after = 1'b1;
               end
               2'd1: begin
                  res.scl_level  = 1'b0;
                  res.sda_level  = 1'b1;
                  res.hold_after = 1'b1;
               end
               2'd2: begin
                  res.scl_level  = 1'b1;
                  res.sda_level  = 1'b1;
                  res.hold_after = 1'b1;
               end
               default: begin
                  res.scl_level = 1'b0;
                  res.sda_level = 1'b1;
                  res.last      = 1'b1;
                  res.ok        = !smp_ff[0];
               end
            endcase
         end
         i2cms_pkg::OP_SEND: begin
            res.scl_level = 1'b0;
            if (step_ff == i2cms_pkg::SEND_LAST_STEP) begin
               res.last = 1'b1;
            end else begin
               res.hold_after = 1'b1;
               unique case (phase_ff)
                  2'd0: ;
                  2'd1: begin
                     res.sda_level = txsh_ff[i2cms_pkg::BYTE_BITS-1];
                     tx_shift      = 1'b1;
                  end
                  default: res.scl_level = 1'b1;
               endcase
            end
         end
         i2cms_pkg::OP_READ: begin
            res.sda_level = 1'b1;
            if (step_ff == '0) begin
               res.scl_level = scl_ff;
            end else if (step_ff == i2cms_pkg::READ_LAST_STEP) begin
               res.scl_level = 1'b0;
               res.last      = 1'b1;
               res.rx_byte   = rx_ff;
            end else if (step_ff[0]) begin
               res.scl_level  = 1'b0;
               res.hold_after = 1'b1;
            end else begin
               res.scl_level  = 1'b1;
               res.hold_after = 1'b1;
               rx_shift       = 1'b1;
            end
         end
         default: res.last = 1'b1;
      endcase
   end

   // Next state, shifters, hold timer and output register
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      step_in        = step_ff;
      phase_in       = phase_ff;
      txsh_in        = txsh_ff;
      smp_in         = smp_ff;
      rx_in          = rx_ff;
      scl_in         = scl_ff;
      sda_in         = sda_ff;
      hold_cycles_in = hold_cycles_ff;
      hold_cnt_in    = hold_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_in         = rsp_ff;

      if (csr_if.valid) begin
         hold_cycles_in = csr_if.payload;
      end

      if (hold_cnt_ff != '0) begin
         hold_cnt_in = hold_cnt_ff - 1'b1;
      end

      if (req_xfer) begin
         op_in    = i2cms_pkg::op_type'(req_if.payload.opcode);
         txsh_in  = req_if.payload.tx_byte;
         smp_in   = req_if.payload.sda_samples;
         rx_in    = '0;
         step_in  = '0;
         phase_in = '0;
         state_in = (req_if.payload.opcode <= 3'(i2cms_pkg::OP_READ)) ? ST_RUN : ST_IDLE;
      end

      if (issue) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
         scl_in       = res.scl_level;
         sda_in       = res.sda_level;
         step_in      = step_ff + 1'b1;
         phase_in     = (phase_ff == 2'd2) ? 2'd0 : phase_ff + 1'b1;
         if (tx_shift) begin
            txsh_in = {txsh_ff[i2cms_pkg::BYTE_BITS-2:0], 1'b0};
         end
         if (rx_shift) begin
            rx_in  = {rx_ff[i2cms_pkg::BYTE_BITS-2:0], smp_ff[i2cms_pkg::BYTE_BITS-1]};
            smp_in = {smp_ff[i2cms_pkg::BYTE_BITS-2:0], 1'b0};
         end
         if (res.hold_after) begin
            hold_cnt_in = (hold_cycles_ff == '0) ? i2cms_pkg::HOLD_W'(1) : hold_cycles_ff;
         end
         if (res.last) begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         hold_cycles_ff <= i2cms_pkg::HOLD_RESET;
         hold_cnt_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         scl_ff         <= scl_in;
         sda_ff         <= sda_in;
         hold_cycles_ff <= hold_cycles_in;
         hold_cnt_ff    <= hold_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      op_ff    <= op_in;
      step_ff  <= step_in;
      phase_ff <= phase_in;
      txsh_ff  <= txsh_in;
      smp_ff   <= smp_in;
      rx_ff    <= rx_in;
      rsp_ff   <= rsp_in;
   end

endmodule

@@ rtl/i2cms_checker.sv @@
module i2cms_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic [2:0]                 req_opcode,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input i2cms_pkg::rsp_payload_type rsp_payload
);

   // A stalled pin change keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("pin change payload changed while stalled");

   // A real command blocks further commands until it finishes
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode != 3'd7) |=> !req_ready)
      else $error("command taken while another is running");

   // ok only on the final change
   a_ok_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.ok |-> rsp_payload.last)
      else $error("ok flagged before the final change");

   // Received byte only on the final change
   a_rx_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.rx_byte != '0) |-> rsp_payload.last)
      else $error("received byte shown before the final change");

endmodule

bind i2c_master_bit_sequencer_core i2cms_checker u_i2cms_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .req_opcode  (req_if.payload.opcode),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);
